[rtl/ntcvt_pkg.sv]
// Shared constants, voltage table and pipeline types for the NTC converter.
`default_nettype none

package ntcvt_pkg;

    localparam int STORED_POINTS     = 25;
    localparam int DEF_TABLE_POINTS  = 25;
    localparam int PT_IDX_W          = $clog2(STORED_POINTS);

    localparam int VOLT_W            = 16;
    localparam int TEMP_W            = 16;
    localparam int SPAN_W            = 12;   // widest segment span is 3605
    localparam int QUOT_W            = 11;   // quotient never exceeds 1280
    localparam int REM_W             = SPAN_W + QUOT_W;

    localparam int START_Q8          = -10240;
    localparam int STEP_Q8           = 1280;

    // configuration port
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LOW     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_HIGH    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VALID_MIN_TEMP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_VALID_MAX_TEMP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_INVALID_CODE   = 3'd4;

    localparam logic [VOLT_W-1:0]        RST_WINDOW_LOW     = 16'd5734;
    localparam logic [VOLT_W-1:0]        RST_WINDOW_HIGH    = 16'd51610;
    localparam logic signed [TEMP_W-1:0] RST_VALID_MIN_TEMP = -16'sd10240;
    localparam logic signed [TEMP_W-1:0] RST_VALID_MAX_TEMP = 16'sd20480;
    localparam logic signed [TEMP_W-1:0] RST_INVALID_CODE   = 16'sh8000;

    // Item moving through the interpolation pipeline.
    typedef struct packed {
        logic signed [TEMP_W-1:0] base;
        logic [REM_W-1:0]         rem;
        logic [SPAN_W-1:0]        span;
        logic [QUOT_W-1:0]        quot;
        logic                     win_ok;
    } t_div;

    // Falling divider voltage table, Q2.14, one point every 5 C from -40 C.
    function automatic logic [VOLT_W-1:0] volt_point(input logic [PT_IDX_W-1:0] idx);
        logic [VOLT_W-1:0] v;
        case (idx)
            5'd0:    v = 16'd52383;
            5'd1:    v = 16'd51814;
            5'd2:    v = 16'd51080;
            5'd3:    v = 16'd50149;
            5'd4:    v = 16'd48967;
            5'd5:    v = 16'd47553;
            5'd6:    v = 16'd45875;
            5'd7:    v = 16'd43866;
            5'd8:    v = 16'd41493;
            5'd9:    v = 16'd38619;
            5'd10:   v = 16'd36045;
            5'd11:   v = 16'd32440;
            5'd12:   v = 16'd29491;
            5'd13:   v = 16'd27034;
            5'd14:   v = 16'd24023;
            5'd15:   v = 16'd21158;
            5'd16:   v = 16'd18485;
            5'd17:   v = 16'd16045;
            5'd18:   v = 16'd13851;
            5'd19:   v = 16'd11910;
            5'd20:   v = 16'd10210;
            5'd21:   v = 16'd8735;
            5'd22:   v = 16'd7466;
            5'd23:   v = 16'd6376;
            5'd24:   v = 16'd5450;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/ntcvt_seg.sv]
// Stage 0: clamp the voltage, find its table segment, set up the division.
`default_nettype none

module ntcvt_seg #(
    parameter int TABLE_POINTS = ntcvt_pkg::DEF_TABLE_POINTS
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [ntcvt_pkg::VOLT_W-1:0]  i_volt,
    input  wire [ntcvt_pkg::VOLT_W-1:0]  i_win_low,
    input  wire [ntcvt_pkg::VOLT_W-1:0]  i_win_high,
    output ntcvt_pkg::t_div              o_item
);
    import ntcvt_pkg::*;

    localparam int NPTS = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                          (TABLE_POINTS < 2) ? 2 : TABLE_POINTS;
    localparam logic signed [TEMP_W-1:0] END_TEMP = TEMP_W'(START_Q8 + STEP_Q8 * (NPTS - 1));

    t_div              n_item;
    t_div              r_item;
    logic              above;
    logic              below;
    logic [VOLT_W-1:0] hi;
    logic [SPAN_W-1:0] d;

    always_comb begin
        above  = (i_volt >= volt_point(PT_IDX_W'(0)));
        below  = (i_volt <= volt_point(PT_IDX_W'(NPTS - 1)));
        hi     = i_volt;
        n_item = '0;
        n_item.span   = SPAN_W'(1);
        n_item.win_ok = (i_volt >= i_win_low) && (i_volt <= i_win_high);
        if (above) begin
            n_item.base = TEMP_W'(START_Q8);
        end else if (below) begin
            n_item.base = END_TEMP;
        end else begin
            // exactly one segment matches strictly inside the table
            for (int i = 1; i < NPTS; i++) begin
                if ((i_volt < volt_point(PT_IDX_W'(i - 1))) &&
                    (i_volt >= volt_point(PT_IDX_W'(i)))) begin
                    hi          = volt_point(PT_IDX_W'(i - 1));
                    n_item.base = TEMP_W'(START_Q8 + STEP_Q8 * (i - 1));
                    n_item.span = SPAN_W'(volt_point(PT_IDX_W'(i - 1)) -
                                          volt_point(PT_IDX_W'(i)));
                end
            end
        end
        d = SPAN_W'(hi - i_volt);
        // offset times 1280 = (d << 10) + (d << 8)
        n_item.rem = (REM_W'(d) << 10) + (REM_W'(d) << 8);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

[rtl/ntcvt_div_stage.sv]
// One registered slice of the restoring divider: a few quotient bits per stage.
`default_nettype none

module ntcvt_div_stage #(
    parameter int FIRST_BIT = 10,
    parameter int STEPS     = 4
) (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  ntcvt_pkg::t_div     i_item,
    output ntcvt_pkg::t_div     o_item
);
    import ntcvt_pkg::*;

    t_div             n_item;
    t_div             r_item;
    logic [REM_W-1:0] sub;

    always_comb begin
        n_item = i_item;
        sub    = '0;
        for (int s = 0; s < STEPS; s++) begin
            sub = REM_W'(i_item.span) << (FIRST_BIT - s);
            if (n_item.rem >= sub) begin
                n_item.rem                    = n_item.rem - sub;
                n_item.quot[FIRST_BIT - s]    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

[rtl/ntcvt_check.sv]
// Last stage: add the quotient to the segment base, run the checks, hold the result.
`default_nettype none

module ntcvt_check (
    input  wire                                i_clk,
    input  wire                                i_en,
    input  ntcvt_pkg::t_div                    i_item,
    input  wire signed [ntcvt_pkg::TEMP_W-1:0] i_min_temp,
    input  wire signed [ntcvt_pkg::TEMP_W-1:0] i_max_temp,
    input  wire signed [ntcvt_pkg::TEMP_W-1:0] i_invalid_code,
    output logic signed [ntcvt_pkg::TEMP_W-1:0] o_raw,
    output logic signed [ntcvt_pkg::TEMP_W-1:0] o_checked,
    output logic                               o_ok
);
    import ntcvt_pkg::*;

    logic signed [TEMP_W-1:0] n_raw;
    logic                     n_ok;
    logic signed [TEMP_W-1:0] r_raw;
    logic signed [TEMP_W-1:0] r_checked;
    logic                     r_ok;

    always_comb begin
        n_raw = i_item.base + $signed({{(TEMP_W - QUOT_W){1'b0}}, i_item.quot});
        n_ok  = i_item.win_ok && (n_raw >= i_min_temp) && (n_raw <= i_max_temp);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_raw     <= n_raw;
            r_checked <= n_ok ? n_raw : i_invalid_code;
            r_ok      <= n_ok;
        end
    end

    assign o_raw     = r_raw;
    assign o_checked = r_checked;
    assign o_ok      = r_ok;

endmodule

`default_nettype wire

[rtl/ntc_voltage_to_temperature.sv]
// Throughput: one transaction per cycle; every stage has its own valid bit and advances
//   whenever its successor has room, so bubbles collapse and stalls drop nothing.
// Stages: segment search, three divider slices (4, 4 and 3 quotient bits), check/output.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
`default_nettype none

// Top level: NTC divider voltage (Q2.14) to temperature (Q8.8) by table interpolation.
module ntc_voltage_to_temperature #(
    parameter int TABLE_POINTS = ntcvt_pkg::DEF_TABLE_POINTS
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // slave side
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire [15:0]                        i_s_axis_tdata,   // [15:0] sense_voltage
    // master side
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [31:0]                       o_m_axis_tdata,   // [15:0] raw_temp,
                                                                // [31:16] checked_temp
    output logic [0:0]                        o_m_axis_tuser,   // [0] temp_valid
    // configuration writes
    input  wire                               i_cfg_we,
    input  wire [ntcvt_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire [ntcvt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import ntcvt_pkg::*;

    localparam int NSTG = 5;

    // configuration registers
    logic [VOLT_W-1:0]        r_win_low;
    logic [VOLT_W-1:0]        r_win_high;
    logic signed [TEMP_W-1:0] r_min_temp;
    logic signed [TEMP_W-1:0] r_max_temp;
    logic signed [TEMP_W-1:0] r_invalid_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_low      <= RST_WINDOW_LOW;
            r_win_high     <= RST_WINDOW_HIGH;
            r_min_temp     <= RST_VALID_MIN_TEMP;
            r_max_temp     <= RST_VALID_MAX_TEMP;
            r_invalid_code <= RST_INVALID_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WINDOW_LOW:     r_win_low      <= i_cfg_wdata;
                CFG_WINDOW_HIGH:    r_win_high     <= i_cfg_wdata;
                CFG_VALID_MIN_TEMP: r_min_temp     <= $signed(i_cfg_wdata);
                CFG_VALID_MAX_TEMP: r_max_temp     <= $signed(i_cfg_wdata);
                CFG_INVALID_CODE:   r_invalid_code <= $signed(i_cfg_wdata);
                default: ;          // drop writes beyond the register list
            endcase
        end
    end

    // Per-stage valid bits and load enables. A stage loads when it is empty
    // or its successor is loading (or, for the last one, the sink takes it).
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG:0]   en;

    always_comb begin
        en[NSTG] = i_m_axis_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k + 1];
        end
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_s_axis_tvalid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = en[0];

    // datapath
    t_div                     w_s0;
    t_div                     w_s1;
    t_div                     w_s2;
    t_div                     w_s3;
    logic signed [TEMP_W-1:0] w_raw;
    logic signed [TEMP_W-1:0] w_checked;
    logic                     w_ok;

    ntcvt_seg #(
        .TABLE_POINTS (TABLE_POINTS)
    ) u_seg (
        .i_clk      (i_clk),
        .i_en       (en[0]),
        .i_volt     (i_s_axis_tdata),
        .i_win_low  (r_win_low),
        .i_win_high (r_win_high),
        .o_item     (w_s0)
    );

    ntcvt_div_stage #(.FIRST_BIT(10), .STEPS(4)) u_div0 (
        .i_clk  (i_clk),
        .i_en   (en[1]),
        .i_item (w_s0),
        .o_item (w_s1)
    );

    ntcvt_div_stage #(.FIRST_BIT(6), .STEPS(4)) u_div1 (
        .i_clk  (i_clk),
        .i_en   (en[2]),
        .i_item (w_s1),
        .o_item (w_s2)
    );

    ntcvt_div_stage #(.FIRST_BIT(2), .STEPS(3)) u_div2 (
        .i_clk  (i_clk),
        .i_en   (en[3]),
        .i_item (w_s2),
        .o_item (w_s3)
    );

    ntcvt_check u_check (
        .i_clk          (i_clk),
        .i_en           (en[4]),
        .i_item         (w_s3),
        .i_min_temp     (r_min_temp),
        .i_max_temp     (r_max_temp),
        .i_invalid_code (r_invalid_code),
        .o_raw          (w_raw),
        .o_checked      (w_checked),
        .o_ok           (w_ok)
    );

    assign o_m_axis_tvalid = r_vld[NSTG - 1];
    assign o_m_axis_tdata  = {w_checked, w_raw};
    assign o_m_axis_tuser  = w_ok;

endmodule

`default_nettype wire

[rtl/ntcvt_checker.sv]
// Port-level checks for the NTC converter, bound to the top level.
`default_nettype none

module ntcvt_checker (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    input  wire [31:0] o_m_axis_tdata,
    input  wire [0:0]  o_m_axis_tuser
);

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // A passing result reports the raw temperature unchanged.
    a_ok_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[31:16] == o_m_axis_tdata[15:0])
        else $error("checked temperature differs from raw on a valid result");

    // Interpolation stays within the table's temperature span (-40 C .. 80 C).
    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[15:0]) >= -16'sd10240) &&
            ($signed(o_m_axis_tdata[15:0]) <= 16'sd20480))
        else $error("raw temperature outside the table span");

endmodule

bind ntc_voltage_to_temperature ntcvt_checker u_ntcvt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
